// File: rtl/core/gft_pkg.sv
// ============================================================================
// gft_pkg - grammar file tokenizer shared definitions
// Result record, event/token/error codes, byte classes and marker names.
// ============================================================================
package gft_pkg;

	localparam int LINE_BITS_DEF = 20;
	localparam int LINE_OUT_W    = 20;

	// event kinds
	localparam logic [1:0] EV_IDENT_BYTE = 2'd0;
	localparam logic [1:0] EV_TOKEN      = 2'd1;
	localparam logic [1:0] EV_ERROR      = 2'd2;

	// token kinds
	localparam logic [3:0] TK_END          = 4'd0;
	localparam logic [3:0] TK_IDENT        = 4'd6;
	localparam logic [3:0] TK_COLON        = 4'd7;
	localparam logic [3:0] TK_BAR          = 4'd8;
	localparam logic [3:0] TK_SEMI         = 4'd9;
	localparam logic [3:0] TK_LBRACKET     = 4'd10;
	localparam logic [3:0] TK_RBRACKET     = 4'd11;

	// error codes
	localparam logic [1:0] ERR_NONE       = 2'd0;
	localparam logic [1:0] ERR_BAD_MARKER = 2'd1;
	localparam logic [1:0] ERR_BAD_CHAR   = 2'd2;

	// byte values
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_BAR   = 8'h7C;

	// section marker names; marker i gives token kind i+1
	localparam int MARKER_NUM    = 5;
	localparam int MARKER_MAXLEN = 12;

	localparam logic [7:0] MARKER_TEXT [MARKER_NUM][MARKER_MAXLEN] = '{
		'{"s", "t", "a", "r", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "e", "r", "m", "i", "n", "a", "l", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"i", "n", "t", "e", "r", "m", "e", "d", "i", "a", "t", "e"},
		'{"g", "r", "a", "m", "m", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [3:0] MARKER_LEN [MARKER_NUM] = '{4'd5, 4'd3, 4'd8, 4'd12, 4'd7};

	// result queue
	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	typedef struct packed {
		logic [1:0]            event_kind;
		logic [3:0]            token_kind;
		logic [7:0]            byte_value;
		logic [LINE_OUT_W-1:0] line_at;
		logic [1:0]            error_code;
		logic                  last;
	} result_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_name(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
			(c >= "a" && c <= "z") || c == CH_UNDER || c == CH_DASH || c == CH_DOT;
	endfunction

	function automatic result_t mk_res(input logic [1:0] kind, input logic [3:0] tok,
		input logic [7:0] value, input logic [1:0] err, input logic [LINE_OUT_W-1:0] line);
		result_t r;
		r.event_kind = kind;
		r.token_kind = tok;
		r.byte_value = value;
		r.line_at    = line;
		r.error_code = err;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

// File: rtl/core/gft_scan.sv
// ============================================================================
// gft_scan - scanner state and per-byte step logic
// Updates mode, marker match state and line count for one byte and forms
// up to two results for it.
// ============================================================================
module gft_scan #(
	parameter int LINE_BITS = gft_pkg::LINE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        char_in,
	input  logic              end_of_input,
	output logic [1:0]        push_cnt,
	output gft_pkg::result_t  res0,
	output gft_pkg::result_t  res1
);

	localparam logic [2:0] MODE_BETWEEN = 3'd0;
	localparam logic [2:0] MODE_COMMENT = 3'd1;
	localparam logic [2:0] MODE_IDENT   = 3'd2;
	localparam logic [2:0] MODE_MARKER  = 3'd3;
	localparam logic [2:0] MODE_HALTED  = 3'd4;

	localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};
	localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

	logic [2:0]                      mode_q, mode_d;
	logic [3:0]                      mpos_q, mpos_d;
	logic [gft_pkg::MARKER_NUM-1:0]  mcand_q, mcand_d;
	logic [LINE_BITS-1:0]            line_q;
	logic                            line_inc;
	logic [gft_pkg::LINE_OUT_W-1:0]  line_out;

	// between-tokens handling of the current byte
	logic                bt_emit, bt_nl, bt_mk;
	logic [2:0]          bt_mode;
	gft_pkg::result_t    bt_res;

	// marker name resolution
	logic [gft_pkg::MARKER_NUM-1:0] fits, hit;
	logic                           fm_ok;
	logic [3:0]                     fm_tok;

	logic             r0_v, r1_v;
	gft_pkg::result_t r0, r1;

	generate
		if (LINE_BITS >= gft_pkg::LINE_OUT_W) begin : g_line_trunc
			assign line_out = line_q[gft_pkg::LINE_OUT_W-1:0];
		end else begin : g_line_ext
			assign line_out = {{(gft_pkg::LINE_OUT_W-LINE_BITS){1'b0}}, line_q};
		end
	endgenerate

	always_comb begin
		bt_emit = 1'b0;
		bt_nl   = 1'b0;
		bt_mk   = 1'b0;
		bt_mode = MODE_BETWEEN;
		bt_res  = gft_pkg::mk_res(gft_pkg::EV_TOKEN, gft_pkg::TK_END, 8'h00,
			gft_pkg::ERR_NONE, line_out);
		priority if (gft_pkg::is_space(char_in)) begin
			bt_nl = (char_in == gft_pkg::CH_NL);
		end else if (char_in == gft_pkg::CH_HASH) begin
			bt_mode = MODE_COMMENT;
		end else if (char_in == gft_pkg::CH_PCT) begin
			bt_mode = MODE_MARKER;
			bt_mk   = 1'b1;
		end else if (char_in == gft_pkg::CH_COLON) begin
			bt_emit = 1'b1;
			bt_res.token_kind = gft_pkg::TK_COLON;
		end else if (char_in == gft_pkg::CH_BAR) begin
			bt_emit = 1'b1;
			bt_res.token_kind = gft_pkg::TK_BAR;
		end else if (char_in == gft_pkg::CH_SEMI) begin
			bt_emit = 1'b1;
			bt_res.token_kind = gft_pkg::TK_SEMI;
		end else if (char_in == gft_pkg::CH_LBRK) begin
			bt_emit = 1'b1;
			bt_res.token_kind = gft_pkg::TK_LBRACKET;
		end else if (char_in == gft_pkg::CH_RBRK) begin
			bt_emit = 1'b1;
			bt_res.token_kind = gft_pkg::TK_RBRACKET;
		end else if (gft_pkg::is_name(char_in)) begin
			bt_emit = 1'b1;
			bt_mode = MODE_IDENT;
			bt_res  = gft_pkg::mk_res(gft_pkg::EV_IDENT_BYTE, gft_pkg::TK_IDENT, char_in,
				gft_pkg::ERR_NONE, line_out);
		end else begin
			bt_emit = 1'b1;
			bt_mode = MODE_HALTED;
			bt_res  = gft_pkg::mk_res(gft_pkg::EV_ERROR, gft_pkg::TK_END, char_in,
				gft_pkg::ERR_BAD_CHAR, line_out);
		end
	end

	// per-name match; names have distinct lengths, lowest index wins anyway
	always_comb begin
		fm_tok = gft_pkg::TK_END;
		for (int i = 0; i < gft_pkg::MARKER_NUM; i++) begin
			fits[i] = (mpos_q < gft_pkg::MARKER_LEN[i]) &&
				(gft_pkg::MARKER_TEXT[i][mpos_q] == char_in);
			hit[i]  = mcand_q[i] && (gft_pkg::MARKER_LEN[i] == mpos_q);
		end
		for (int i = gft_pkg::MARKER_NUM - 1; i >= 0; i--) begin
			if (hit[i])
				fm_tok = 4'(i + 1);
		end
		fm_ok = |hit;
	end

	always_comb begin
		mode_d   = mode_q;
		mpos_d   = mpos_q;
		mcand_d  = mcand_q;
		line_inc = 1'b0;
		r0_v     = 1'b0;
		r1_v     = 1'b0;
		r0       = gft_pkg::mk_res(gft_pkg::EV_TOKEN, gft_pkg::TK_END, 8'h00,
			gft_pkg::ERR_NONE, line_out);
		r1       = r0;
		if (mode_q == MODE_HALTED) begin
			// stays halted until reset
		end else if (end_of_input) begin
			mode_d = MODE_BETWEEN;
			r0_v   = 1'b1;
			if (mode_q == MODE_IDENT) begin
				r0.token_kind = gft_pkg::TK_IDENT;
				r1_v = 1'b1;
			end else if (mode_q == MODE_MARKER) begin
				if (fm_ok) begin
					r0.token_kind = fm_tok;
					r1_v = 1'b1;
				end else begin
					mode_d = MODE_HALTED;
					r0 = gft_pkg::mk_res(gft_pkg::EV_ERROR, gft_pkg::TK_END, 8'h00,
						gft_pkg::ERR_BAD_MARKER, line_out);
				end
			end
		end else begin
			unique case (mode_q)
				MODE_COMMENT: begin
					if (char_in == gft_pkg::CH_NL) begin
						line_inc = 1'b1;
						mode_d   = MODE_BETWEEN;
					end
				end
				MODE_IDENT: begin
					r0_v = 1'b1;
					if (gft_pkg::is_name(char_in)) begin
						r0 = gft_pkg::mk_res(gft_pkg::EV_IDENT_BYTE, gft_pkg::TK_IDENT,
							char_in, gft_pkg::ERR_NONE, line_out);
					end else begin
						r0.token_kind = gft_pkg::TK_IDENT;
						r1_v     = bt_emit;
						r1       = bt_res;
						mode_d   = bt_mode;
						line_inc = bt_nl;
						if (bt_mk) begin
							mpos_d  = '0;
							mcand_d = '1;
						end
					end
				end
				MODE_MARKER: begin
					if (gft_pkg::is_name(char_in)) begin
						mcand_d = mcand_q & fits;
						if (mpos_q != 4'hF)
							mpos_d = mpos_q + 4'd1;
					end else if (fm_ok) begin
						r0_v = 1'b1;
						r0.token_kind = fm_tok;
						r1_v     = bt_emit;
						r1       = bt_res;
						mode_d   = bt_mode;
						line_inc = bt_nl;
						if (bt_mk) begin
							mpos_d  = '0;
							mcand_d = '1;
						end
					end else begin
						r0_v   = 1'b1;
						mode_d = MODE_HALTED;
						r0 = gft_pkg::mk_res(gft_pkg::EV_ERROR, gft_pkg::TK_END, char_in,
							gft_pkg::ERR_BAD_MARKER, line_out);
					end
				end
				default: begin
					r0_v     = bt_emit;
					r0       = bt_res;
					mode_d   = bt_mode;
					line_inc = bt_nl;
					if (bt_mk) begin
						mpos_d  = '0;
						mcand_d = '1;
					end
				end
			endcase
		end
	end

	always_comb begin
		res0      = r0;
		res1      = r1;
		res0.last = !r1_v;
		res1.last = 1'b1;
		if (!step || !r0_v)
			push_cnt = 2'd0;
		else if (r1_v)
			push_cnt = 2'd2;
		else
			push_cnt = 2'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BETWEEN;
			mpos_q  <= '0;
			mcand_q <= '1;
			line_q  <= LINE_ONE;
		end else if (step) begin
			mode_q  <= mode_d;
			mpos_q  <= mpos_d;
			mcand_q <= mcand_d;
			if (line_inc && line_q != LINE_MAX)
				line_q <= line_q + LINE_ONE;
		end
	end

`ifndef SYNTHESIS
	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_HALTED) |-> (push_cnt == 2'd0))
		else $error("gft_scan: result produced while halted");
	a_halt_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0 && ((res0.event_kind == gft_pkg::EV_ERROR) ||
		(push_cnt == 2'd2 && res1.event_kind == gft_pkg::EV_ERROR)))
		|=> (mode_q == MODE_HALTED))
		else $error("gft_scan: error did not halt the scanner");
`endif

endmodule

// File: rtl/core/gft_rqueue.sv
// ============================================================================
// gft_rqueue - result queue
// Small register queue taking up to two results per cycle, giving one.
// ============================================================================
module gft_rqueue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_cnt,
	input  gft_pkg::result_t  d0,
	input  gft_pkg::result_t  d1,
	output logic              room,
	input  logic              pop,
	output logic              q_valid,
	output gft_pkg::result_t  q
);

	gft_pkg::result_t                entry_q [gft_pkg::RQ_DEPTH];
	logic [gft_pkg::RQ_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [gft_pkg::RQ_CNT_W-1:0]    count_q;
	logic                            do_pop;

	assign q_valid = (count_q != '0);
	assign q       = entry_q[rd_ptr_q];
	assign do_pop  = pop && q_valid;
	assign room    = (count_q <= gft_pkg::RQ_CNT_W'(gft_pkg::RQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			entry_q[wr_ptr_q] <= d0;
		if (push_cnt == 2'd2)
			entry_q[wr_ptr_q + gft_pkg::RQ_PTR_W'(1)] <= d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + gft_pkg::RQ_PTR_W'(push_cnt);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + gft_pkg::RQ_PTR_W'(1);
			count_q <= count_q + gft_pkg::RQ_CNT_W'(push_cnt)
				- gft_pkg::RQ_CNT_W'(do_pop);
		end
	end

`ifndef SYNTHESIS
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= gft_pkg::RQ_CNT_W'(gft_pkg::RQ_DEPTH))
		else $error("gft_rqueue: level beyond depth");
`endif

endmodule

// File: rtl/core/grammar_file_tokenizer_core.sv
// ============================================================================
// grammar_file_tokenizer_core - byte-stream tokenizer for grammar text
// Input register, scanner step logic and a result queue.
// ============================================================================
// Usage:
//  Item channel (item_valid/item_ready): one transfer per text byte on
//  char_in, or an end-of-text mark with end_of_input high (char_in ignored).
//  Result channel (result_valid/result_ready): zero, one or two results per
//  item: identifier bytes, completed tokens or a lexical error. last is set
//  on the final result of an item. line_at is the line count when the item
//  was scanned.
//  Flow: an accepted item is held in the input register and scanned from there;
//  its results are written to the result queue, which offers them.
//  Throughput: one item per cycle while results drain; the results of an item
//  leave the queue one at a time.
//  Stall: the scan stage advances only while the four-entry result queue has
//  room for two results; otherwise the input register holds its item and
//  item_ready follows.
//  Reset: scanner between tokens, line count one, queue empty. After an
//  error the scanner stays halted: items are still taken but give no results
//  until the next reset.
// ============================================================================
module grammar_file_tokenizer_core #(
	parameter int LINE_BITS = gft_pkg::LINE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [7:0]                     char_in,
	input  logic                           end_of_input,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [1:0]                     event_kind,
	output logic [3:0]                     token_kind,
	output logic [7:0]                     byte_value,
	output logic [gft_pkg::LINE_OUT_W-1:0] line_at,
	output logic [1:0]                     error_code,
	output logic                           last
);

	// input register
	logic             valid_s1;
	logic [7:0]       char_s1;
	logic             eoi_s1;

	logic             room, adv;
	logic [1:0]       push_cnt;
	gft_pkg::result_t res0, res1, head;

	// scan stage fires when the queue can take a worst-case pair
	assign adv        = valid_s1 && room;
	assign item_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			char_s1 <= char_in;
			eoi_s1  <= end_of_input;
		end
	end

	gft_scan #(
		.LINE_BITS(LINE_BITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.char_in      (char_s1),
		.end_of_input (eoi_s1),
		.push_cnt     (push_cnt),
		.res0         (res0),
		.res1         (res1)
	);

	gft_rqueue u_rqueue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.d0       (res0),
		.d1       (res1),
		.room     (room),
		.pop      (result_ready),
		.q_valid  (result_valid),
		.q        (head)
	);

	assign event_kind = head.event_kind;
	assign token_kind = head.token_kind;
	assign byte_value = head.byte_value;
	assign line_at    = head.line_at;
	assign error_code = head.error_code;
	assign last       = head.last;

`ifndef SYNTHESIS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room) |=> (valid_s1 && $stable(char_s1) && $stable(eoi_s1)))
		else $error("tokenizer: stalled input register changed");
	a_push_only_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> adv)
		else $error("tokenizer: results pushed without a scan step");
	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && event_kind == gft_pkg::EV_ERROR) |-> last)
		else $error("tokenizer: error result not marked last");
`endif

endmodule
